### hdl/segment_intersection_unit_assert.svh
// assertion macros for the segment intersection unit checker
`ifndef SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_UNIT_ASSERT_SVH

// same-cycle implication
`define SIU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("siu assertion failed");

// implication after a fixed delay
`define SIU_ASSERT_DLY(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("siu assertion failed");

`endif

### hdl/siu_pkg.sv
// types, widths and constants of the segment intersection unit
package siu_pkg;

	localparam int COORD_BITS  = 16;
	localparam int T_FRAC_BITS = 16;

	// coordinate differences
	localparam int DW = COORD_BITS + 1;
	// cross products
	localparam int XW = 2 * COORD_BITS + 3;
	// crossing numerators
	localparam int NXW = 3 * COORD_BITS + 5;
	localparam int NTW = XW + T_FRAC_BITS;
	localparam int NW  = (NXW > NTW) ? NXW : NTW;
	// quotient bits, one divider cell each
	localparam int QB = (COORD_BITS > T_FRAC_BITS + 1) ? COORD_BITS : T_FRAC_BITS + 1;
	// remainder width
	localparam int RW = ((NW > XW + QB) ? NW : XW + QB) + 1;
	// start to strobe, in cycles
	localparam int LAT = QB + 5;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_start_x;
		logic signed [COORD_BITS-1:0] a_start_y;
		logic signed [COORD_BITS-1:0] a_end_x;
		logic signed [COORD_BITS-1:0] a_end_y;
		logic signed [COORD_BITS-1:0] b_start_x;
		logic signed [COORD_BITS-1:0] b_start_y;
		logic signed [COORD_BITS-1:0] b_end_x;
		logic signed [COORD_BITS-1:0] b_end_y;
	} operands_t;

	typedef struct packed {
		logic                          hit;
		logic signed [COORD_BITS-1:0]  cross_x;
		logic signed [COORD_BITS-1:0]  cross_y;
		logic [T_FRAC_BITS:0]          param_t;
	} result_t;

	// data carried from one divider cell to the next
	typedef struct packed {
		logic           hit;
		logic           neg_x;
		logic           neg_y;
		logic           neg_t;
		logic           ovf_x;
		logic           ovf_y;
		logic           ovf_t;
		logic [RW-1:0]  rem_x;
		logic [RW-1:0]  rem_y;
		logic [RW-1:0]  rem_t;
		logic [XW-1:0]  dmag;
		logic [QB-1:0]  q_x;
		logic [QB-1:0]  q_y;
		logic [QB-1:0]  q_t;
	} cell_t;

	// 2d cross product of two difference vectors
	function automatic logic signed [XW-1:0] cross2d(
		input logic signed [DW-1:0] ax,
		input logic signed [DW-1:0] ay,
		input logic signed [DW-1:0] bx,
		input logic signed [DW-1:0] by
	);
		logic signed [2*DW-1:0] p1;
		logic signed [2*DW-1:0] p2;
		p1 = ax * by;
		p2 = ay * bx;
		return XW'(p1) - XW'(p2);
	endfunction

endpackage

### hdl/siu_front.sv
// front pipeline: differences, cross products, numerators, magnitudes
module siu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  siu_pkg::operands_t   operands,
	output logic                 valid,
	output siu_pkg::cell_t       div_data
);

	localparam int DW = siu_pkg::DW;
	localparam int XW = siu_pkg::XW;
	localparam int NW = siu_pkg::NW;
	localparam int RW = siu_pkg::RW;
	localparam int QB = siu_pkg::QB;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1;
	logic signed [DW-1:0] wx_s1, wy_s1, fx_s1, fy_s1, gx_s1, gy_s1, hx_s1, hy_s1;
	logic signed [DW-1:0] a0x_s1, a0y_s1, b0x_s1, b0y_s1;

	logic signed [DW-1:0] dax_s2, day_s2, dbx_s2, dby_s2;
	logic signed [XW-1:0] den_s2, ca_s2, cb_s2, ct_s2;
	logic                 hit_s2;

	logic signed [NW-1:0] nx_s3, ny_s3, nt_s3;
	logic signed [XW-1:0] den_s3;
	logic                 hit_s3;

	siu_pkg::cell_t cell_s4;

	logic signed [XW-1:0] o1, o2, o3, o4;
	logic                 hit_c;
	logic signed [DW+XW-1:0] pxb, pxa, pyb, pya;
	logic [NW-1:0] mx, my, mt;
	logic [XW-1:0] md;
	logic [RW-1:0] dlim;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 1: differences
	always_ff @(posedge clk) begin
		dax_s1 <= DW'(operands.a_end_x) - DW'(operands.a_start_x);
		day_s1 <= DW'(operands.a_end_y) - DW'(operands.a_start_y);
		dbx_s1 <= DW'(operands.b_end_x) - DW'(operands.b_start_x);
		dby_s1 <= DW'(operands.b_end_y) - DW'(operands.b_start_y);
		wx_s1  <= DW'(operands.b_start_x) - DW'(operands.a_start_x);
		wy_s1  <= DW'(operands.b_start_y) - DW'(operands.a_start_y);
		fx_s1  <= DW'(operands.b_end_x) - DW'(operands.a_start_x);
		fy_s1  <= DW'(operands.b_end_y) - DW'(operands.a_start_y);
		gx_s1  <= DW'(operands.a_start_x) - DW'(operands.b_start_x);
		gy_s1  <= DW'(operands.a_start_y) - DW'(operands.b_start_y);
		hx_s1  <= DW'(operands.a_end_x) - DW'(operands.b_start_x);
		hy_s1  <= DW'(operands.a_end_y) - DW'(operands.b_start_y);
		a0x_s1 <= DW'(operands.a_start_x);
		a0y_s1 <= DW'(operands.a_start_y);
		b0x_s1 <= DW'(operands.b_start_x);
		b0y_s1 <= DW'(operands.b_start_y);
	end

	// stage 2: orientations and cross products
	always_comb begin
		o1 = siu_pkg::cross2d(dax_s1, day_s1, wx_s1, wy_s1);
		o2 = siu_pkg::cross2d(dax_s1, day_s1, fx_s1, fy_s1);
		o3 = siu_pkg::cross2d(dbx_s1, dby_s1, gx_s1, gy_s1);
		o4 = siu_pkg::cross2d(dbx_s1, dby_s1, hx_s1, hy_s1);
		hit_c = ((!o1[XW-1] && (o1 != '0)) != (!o2[XW-1] && (o2 != '0))) &&
		        ((!o3[XW-1] && (o3 != '0)) != (!o4[XW-1] && (o4 != '0)));
	end

	always_ff @(posedge clk) begin
		hit_s2 <= hit_c;
		den_s2 <= siu_pkg::cross2d(dax_s1, day_s1, dbx_s1, dby_s1);
		ca_s2  <= siu_pkg::cross2d(a0x_s1, a0y_s1, dax_s1, day_s1);
		cb_s2  <= siu_pkg::cross2d(b0x_s1, b0y_s1, dbx_s1, dby_s1);
		ct_s2  <= siu_pkg::cross2d(wx_s1, wy_s1, dbx_s1, dby_s1);
		dax_s2 <= dax_s1;
		day_s2 <= day_s1;
		dbx_s2 <= dbx_s1;
		dby_s2 <= dby_s1;
	end

	// stage 3: numerators
	always_comb begin
		pxb = dax_s2 * cb_s2;
		pxa = dbx_s2 * ca_s2;
		pyb = day_s2 * cb_s2;
		pya = dby_s2 * ca_s2;
	end

	always_ff @(posedge clk) begin
		nx_s3  <= NW'(pxb) - NW'(pxa);
		ny_s3  <= NW'(pyb) - NW'(pya);
		nt_s3  <= NW'(ct_s2) <<< siu_pkg::T_FRAC_BITS;
		den_s3 <= den_s2;
		hit_s3 <= hit_s2;
	end

	// stage 4: signs, magnitudes and overflow checks
	always_comb begin
		mx   = nx_s3[NW-1] ? NW'(-nx_s3) : NW'(nx_s3);
		my   = ny_s3[NW-1] ? NW'(-ny_s3) : NW'(ny_s3);
		mt   = nt_s3[NW-1] ? NW'(-nt_s3) : NW'(nt_s3);
		md   = den_s3[XW-1] ? XW'(-den_s3) : XW'(den_s3);
		dlim = RW'(md) << QB;
	end

	always_ff @(posedge clk) begin
		cell_s4.hit   <= hit_s3;
		cell_s4.neg_x <= nx_s3[NW-1] ^ den_s3[XW-1];
		cell_s4.neg_y <= ny_s3[NW-1] ^ den_s3[XW-1];
		cell_s4.neg_t <= nt_s3[NW-1] ^ den_s3[XW-1];
		cell_s4.ovf_x <= RW'(mx) >= dlim;
		cell_s4.ovf_y <= RW'(my) >= dlim;
		cell_s4.ovf_t <= RW'(mt) >= dlim;
		cell_s4.rem_x <= RW'(mx);
		cell_s4.rem_y <= RW'(my);
		cell_s4.rem_t <= RW'(mt);
		cell_s4.dmag  <= md;
		cell_s4.q_x   <= '0;
		cell_s4.q_y   <= '0;
		cell_s4.q_t   <= '0;
	end

	assign valid    = valid_s4;
	assign div_data = cell_s4;

endmodule

### hdl/siu_div_cell.sv
// one restoring division cell: settles one quotient bit of all three quotients
module siu_div_cell #(
	parameter int SHIFT = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  siu_pkg::cell_t  cell_in,
	output logic            valid_out,
	output siu_pkg::cell_t  cell_out
);

	localparam int RW = siu_pkg::RW;

	logic [RW-1:0] dsh;
	logic          gx, gy, gt;
	logic          valid_q;
	siu_pkg::cell_t cell_nxt;
	siu_pkg::cell_t cell_q;

	// compare against the shifted divisor
	always_comb begin
		dsh = RW'(cell_in.dmag) << SHIFT;
		gx  = cell_in.rem_x >= dsh;
		gy  = cell_in.rem_y >= dsh;
		gt  = cell_in.rem_t >= dsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	// subtract where it fits and set the quotient bit
	always_comb begin
		cell_nxt = cell_in;
		if (gx) begin
			cell_nxt.rem_x      = cell_in.rem_x - dsh;
			cell_nxt.q_x[SHIFT] = 1'b1;
		end
		if (gy) begin
			cell_nxt.rem_y      = cell_in.rem_y - dsh;
			cell_nxt.q_y[SHIFT] = 1'b1;
		end
		if (gt) begin
			cell_nxt.rem_t      = cell_in.rem_t - dsh;
			cell_nxt.q_t[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= cell_nxt;
	end

	assign valid_out = valid_q;
	assign cell_out  = cell_q;

endmodule

### hdl/segment_intersection_unit.sv
// segment intersection unit: orientation test and pipelined crossing point division
//
//  channel   | signals                | handshake
//  ----------+------------------------+-----------------------------------
//  operands  | start, busy, operands  | taken when start high, busy low
//  result    | done, result           | one cycle strobe, cannot be held
//
// one transaction per cycle; busy is always low
// the result of a start passes through four front stages, one divider cell per quotient bit
// and one output register
// reset clears the valid chain only; no state is kept between transactions
module segment_intersection_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  siu_pkg::operands_t  operands,
	output logic                done,
	output siu_pkg::result_t    result
);

	localparam int QB = siu_pkg::QB;
	localparam int CB = siu_pkg::COORD_BITS;
	localparam int TB = siu_pkg::T_FRAC_BITS;
	localparam logic [QB-1:0] XPOS = (QB'(1) << (CB - 1)) - QB'(1);
	localparam logic [QB-1:0] XNEG = QB'(1) << (CB - 1);
	localparam logic [QB-1:0] TMAX = QB'(1) << TB;

	logic           vchain [QB+1];
	siu_pkg::cell_t cchain [QB+1];
	siu_pkg::result_t res_c;
	logic           done_q;
	siu_pkg::result_t result_q;

	assign busy = 1'b0;

	siu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (start && !busy),
		.operands (operands),
		.valid    (vchain[0]),
		.div_data (cchain[0])
	);

	// divider cells, most significant quotient bit first
	for (genvar i = 0; i < QB; i++) begin : g_cell
		siu_div_cell #(.SHIFT(QB - 1 - i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (vchain[i]),
			.cell_in   (cchain[i]),
			.valid_out (vchain[i+1]),
			.cell_out  (cchain[i+1])
		);
	end

	// coordinate saturation
	function automatic logic signed [CB-1:0] clamp_coord(
		input logic neg, input logic ovf, input logic [QB-1:0] q
	);
		if (neg) begin
			return (ovf || q > XNEG) ? CB'(XNEG) : -CB'(q);
		end
		return (ovf || q > XPOS) ? CB'(XPOS) : CB'(q);
	endfunction

	// saturation and zeroing on a miss
	always_comb begin
		res_c = '0;
		if (cchain[QB].hit) begin
			res_c.hit     = 1'b1;
			res_c.cross_x = clamp_coord(cchain[QB].neg_x, cchain[QB].ovf_x, cchain[QB].q_x);
			res_c.cross_y = clamp_coord(cchain[QB].neg_y, cchain[QB].ovf_y, cchain[QB].q_y);
			if (cchain[QB].neg_t) begin
				res_c.param_t = '0;
			end else if (cchain[QB].ovf_t || cchain[QB].q_t > TMAX) begin
				res_c.param_t = (TB+1)'(TMAX);
			end else begin
				res_c.param_t = (TB+1)'(cchain[QB].q_t);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vchain[QB];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### hdl/siu_checker.sv
// port checker for the segment intersection unit, bound to the top level
`include "segment_intersection_unit_assert.svh"

module siu_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input siu_pkg::result_t    result
);

	localparam int LAT = siu_pkg::LAT;
	localparam logic [siu_pkg::T_FRAC_BITS:0] TONE =
		(siu_pkg::T_FRAC_BITS+1)'(1) << siu_pkg::T_FRAC_BITS;

	logic fields_zero;

	// all data fields clear
	assign fields_zero = result.cross_x == '0 && result.cross_y == '0 &&
		result.param_t == '0;

	// every accepted transaction gives a strobe after the fixed latency
	`SIU_ASSERT_DLY(a_latency, clk, arst_n, start && !busy, LAT, done)
	// a miss carries zero fields
	`SIU_ASSERT_IMP(a_miss_zero, clk, arst_n, done && !result.hit, fields_zero)
	// parameter never exceeds one
	`SIU_ASSERT_IMP(a_t_range, clk, arst_n, done, result.param_t <= TONE)

endmodule

bind segment_intersection_unit siu_checker u_siu_checker (.*);

### tb/sv/tb_segment_intersection_unit.sv
// self-checking testbench for the segment intersection unit
module tb_segment_intersection_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1330;
	localparam int CALM_TAIL = 200;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	siu_pkg::operands_t operands;
	logic done;
	siu_pkg::result_t result;

	siu_pkg::operands_t pending_pairs[$];
	siu_pkg::result_t expected_crossings[$];
	int n_errors = 0;
	int n_sent = 0;
	int n_total = 0;
	int n_checked = 0;
	int n_hits = 0;
	int drain_at = 0;
	int idle_cnt = 0;
	bit took = 0;
	bit stim_ready = 0;

	segment_intersection_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operands(operands),
		.done(done),
		.result(result)
	);

	// clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// 2d cross product
	function automatic longint xprod(longint ax, longint ay, longint bx, longint by);
		return ax * by - ay * bx;
	endfunction

	// strictly positive turn from p to q to r
	function automatic bit turns_left(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		return xprod(qx - px, qy - py, rx - px, ry - py) > 0;
	endfunction

	// quotient truncated toward zero then saturated
	function automatic longint sat_div(longint n, longint d, longint lo, longint hi);
		longint q;
		if (d == 0) return 0;
		q = n / d;
		if (q < lo) return lo;
		if (q > hi) return hi;
		return q;
	endfunction

	// expected crossing for one segment pair
	function automatic siu_pkg::result_t predict_crossing(siu_pkg::operands_t op);
		siu_pkg::result_t r;
		longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		longint dax, day, dbx, dby, den, ca, cb;
		bit hit;
		ax0 = op.a_start_x; ay0 = op.a_start_y; ax1 = op.a_end_x; ay1 = op.a_end_y;
		bx0 = op.b_start_x; by0 = op.b_start_y; bx1 = op.b_end_x; by1 = op.b_end_y;
		r = '0;
		hit = (turns_left(ax0, ay0, ax1, ay1, bx0, by0) !=
				turns_left(ax0, ay0, ax1, ay1, bx1, by1)) &&
			(turns_left(bx0, by0, bx1, by1, ax0, ay0) !=
				turns_left(bx0, by0, bx1, by1, ax1, ay1));
		if (!hit) return r;
		dax = ax1 - ax0; day = ay1 - ay0;
		dbx = bx1 - bx0; dby = by1 - by0;
		den = xprod(dax, day, dbx, dby);
		ca = xprod(ax0, ay0, dax, day);
		cb = xprod(bx0, by0, dbx, dby);
		r.hit = 1'b1;
		r.cross_x = siu_pkg::COORD_BITS'(sat_div(dax * cb - dbx * ca, den, -32768, 32767));
		r.cross_y = siu_pkg::COORD_BITS'(sat_div(day * cb - dby * ca, den, -32768, 32767));
		r.param_t = (siu_pkg::T_FRAC_BITS + 1)'(sat_div(
			xprod(bx0 - ax0, by0 - ay0, dbx, dby) * (64'sd1 <<< siu_pkg::T_FRAC_BITS),
			den, 0, 64'sd1 <<< siu_pkg::T_FRAC_BITS));
		return r;
	endfunction

	function automatic siu_pkg::operands_t make_pair(longint ax0, longint ay0, longint ax1,
			longint ay1, longint bx0, longint by0, longint bx1, longint by1);
		siu_pkg::operands_t op;
		op.a_start_x = siu_pkg::COORD_BITS'(ax0); op.a_start_y = siu_pkg::COORD_BITS'(ay0);
		op.a_end_x = siu_pkg::COORD_BITS'(ax1); op.a_end_y = siu_pkg::COORD_BITS'(ay1);
		op.b_start_x = siu_pkg::COORD_BITS'(bx0); op.b_start_y = siu_pkg::COORD_BITS'(by0);
		op.b_end_x = siu_pkg::COORD_BITS'(bx1); op.b_end_y = siu_pkg::COORD_BITS'(by1);
		return op;
	endfunction

	function automatic longint rnd_range(int span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	// random pair, shaped to cross in half of the draws
	function automatic siu_pkg::operands_t random_pair();
		siu_pkg::operands_t op;
		longint ax0, ay0, ax1, ay1, px, py, vx, vy;
		int kind;
		kind = $urandom_range(0, 9);
		ax0 = rnd_range(16000); ay0 = rnd_range(16000);
		ax1 = rnd_range(16000); ay1 = rnd_range(16000);
		px = (ax0 + ax1) / 2 + rnd_range(200);
		py = (ay0 + ay1) / 2 + rnd_range(200);
		vx = rnd_range(8000); vy = rnd_range(8000);
		case (kind)
			0, 1: begin
				op = {$urandom, $urandom, $urandom, $urandom};
			end
			2: begin
				op = make_pair(rnd_range(32), rnd_range(32), rnd_range(32), rnd_range(32),
					rnd_range(32), rnd_range(32), rnd_range(32), rnd_range(32));
			end
			3: begin
				// endpoint of b lying on a
				op = make_pair(ax0, ay0, ax1, ay1, (ax0 + ax1) / 2 + vx, (ay0 + ay1) / 2 + vy,
					ax0 + (ax1 - ax0) * 0, ay0 + (ay1 - ay0) * 0);
				if ($urandom_range(0, 1)) op = make_pair(ax0, ay0, ax1, ay1, ax1, ay1,
					px + vx, py + vy);
			end
			4: begin
				// collinear or degenerate
				if ($urandom_range(0, 1))
					op = make_pair(ax0, ay0, ax1, ay1, px, py, px, py);
				else
					op = make_pair(0, 0, vx, vy, vx / 2, vy / 2, vx * 2, vy * 2);
			end
			default: begin
				op = make_pair(ax0, ay0, ax1, ay1, px + vx, py + vy,
					px - vx / longint'($urandom_range(1, 4)),
					py - vy / longint'($urandom_range(1, 4)));
				if ($urandom_range(0, 1)) op = {op[63:0], op[127:64]};
			end
		endcase
		return op;
	endfunction

	// one line per mismatch
	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		n_errors++;
	endtask

	// stimulus
	initial begin
		// extremes, crossing, touches, collinear, degenerate, parallel
		pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
			-32768, 32767, 32767, -32768));
		pending_pairs.push_back(make_pair(32767, 32767, -32768, -32768,
			32767, -32768, -32768, 32767));
		pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768));
		pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767));
		pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
		pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 32767, -32768, 32767, 32767));
		pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, -32768, -32768, -32768, 32767));
		pending_pairs.push_back(make_pair(0, 0, 100, 0, 50, 0, 50, 100));
		pending_pairs.push_back(make_pair(0, 0, 100, 0, 100, 0, 100, 100));
		pending_pairs.push_back(make_pair(0, 0, 100, 0, 0, 0, 0, 100));
		pending_pairs.push_back(make_pair(0, 0, 100, 0, 50, 50, 50, -50));
		pending_pairs.push_back(make_pair(0, 0, 100, 0, 50, 0, 150, 0));
		pending_pairs.push_back(make_pair(0, 0, 100, 0, 200, 0, 300, 0));
		pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 5, 5, 5, 5));
		pending_pairs.push_back(make_pair(0, 0, 100, 0, 0, 10, 100, 10));
		pending_pairs.push_back(make_pair(0, 0, 3, 7, 0, 7, 3, 0));
		pending_pairs.push_back(make_pair(-1, -1, 2, 1, 1, -2, -1, 3));
		pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
			-32768, -32768, 32767, 32767));
		pending_pairs.push_back(make_pair(0, 0, 100, 0, 200, -50, 200, 50));
		drain_at = pending_pairs.size();
		for (int i = 0; i < N_RANDOM; i++) pending_pairs.push_back(random_pair());
		n_total = pending_pairs.size();
		stim_ready = 1;
	end

	// reset and end of run
	initial begin
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		wait (stim_ready && n_sent == n_total);
		@(posedge clk);
		while (start || expected_crossings.size() != 0) @(posedge clk);
		repeat (siu_pkg::LAT + 10) @(posedge clk);
		$display("covered %0d segment pairs, %0d results checked, %0d crossings",
			n_total, n_checked, n_hits);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// driver: one transaction per start, random gaps, pause to drain once
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			operands <= '0;
		end else if (start && !took) begin
			start <= 1'b1;
		end else if (idle_cnt > 0 || !stim_ready || pending_pairs.size() == 0 ||
				(n_sent == drain_at && expected_crossings.size() != 0)) begin
			if (idle_cnt > 0) idle_cnt--;
			start <= 1'b0;
		end else begin
			operands <= pending_pairs.pop_front();
			start <= 1'b1;
			n_sent++;
			if (n_sent < n_total - CALM_TAIL && $urandom_range(0, 7) == 0)
				idle_cnt = $urandom_range(1, 10);
		end
	end

	// monitor: check results, then log accepted transactions
	always @(posedge clk) begin
		siu_pkg::result_t want;
		took = 1'b0;
		if (arst_n) begin
			if (done) begin
				if (expected_crossings.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = expected_crossings.pop_front();
					n_checked++;
					if (want.hit) n_hits++;
					if (result.hit !== want.hit)
						report_mismatch("hit", result.hit, want.hit);
					if (result.cross_x !== want.cross_x)
						report_mismatch("cross_x", result.cross_x, want.cross_x);
					if (result.cross_y !== want.cross_y)
						report_mismatch("cross_y", result.cross_y, want.cross_y);
					if (result.param_t !== want.param_t)
						report_mismatch("param_t", result.param_t, want.param_t);
				end
			end
			if (start && !busy) begin
				took = 1'b1;
				expected_crossings.push_back(predict_crossing(operands));
			end
		end
	end

endmodule

### files.f
+incdir+hdl
hdl/siu_pkg.sv
hdl/siu_front.sv
hdl/siu_div_cell.sv
hdl/segment_intersection_unit.sv
hdl/siu_checker.sv
tb/sv/tb_segment_intersection_unit.sv
